// File: rtl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Types and constants shared by the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KEY_W    = 63;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REM_W    = 3;
  localparam int unsigned UTF_KEEP = 23;

  localparam logic [BYTE_W-1:0] CHAR_ESC       = 8'h1B;
  localparam logic [BYTE_W-1:0] CHAR_CSI       = 8'h5B;
  localparam logic [BYTE_W-1:0] CHAR_SS_N      = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_SS_O      = 8'h4F;
  localparam logic [BYTE_W-1:0] CHAR_ALT_LO    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_ALT_HI    = 8'h7A;
  localparam logic [BYTE_W-1:0] CSI_FINAL_LO   = 8'h40;
  localparam logic [BYTE_W-1:0] CSI_FINAL_HI   = 8'hEE;
  localparam logic [BYTE_W-1:0] PLAIN_MAX      = 8'h80;
  localparam logic [BYTE_W-1:0] UTF_LEAD_MIN   = 8'hC0;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_CSI  = 3'd2,
    MODE_SS   = 3'd3,
    MODE_UTF8 = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_KEY      = 3'd0,
    ST_EOI      = 3'd1,
    ST_CSI_LONG = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_BAD_LEAD = 3'd4,
    ST_UTF_LONG = 3'd5
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [KEY_W-1:0]  acc;
    logic [REM_W-1:0]  remaining;
    logic              too_long;
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key_code;
    status_t           status;
  } result_t;

endpackage

// File: rtl/tksd_if.sv
// ----------------------------------------------------------------------------
// tksd_byte_if / tksd_key_if
// Valid/ready channels for terminal bytes and decoded key requests.
// ----------------------------------------------------------------------------
interface tksd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [tksd_pkg::BYTE_W-1:0] in_byte;
  logic                        end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface tksd_key_if;
  logic                          valid;
  logic                          ready;
  logic [tksd_pkg::KEY_W-1:0]    key_code;
  logic [tksd_pkg::STATUS_W-1:0] status;

  modport source (output valid, output key_code, output status, input ready);
  modport sink   (input valid, input key_code, input status, output ready);
endinterface

// File: rtl/tksd_step.sv
// ----------------------------------------------------------------------------
// tksd_step
// Next parse state and optional result for one terminal byte.
// ----------------------------------------------------------------------------
module tksd_step (
  input  tksd_pkg::parse_state_t        cur,
  input  logic [tksd_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          end_of_input,
  output tksd_pkg::parse_state_t        nxt,
  output tksd_pkg::result_t             res
);

  logic [tksd_pkg::KEY_W-1:0] shifted;
  logic [tksd_pkg::KEY_W-1:0] utf_acc;
  logic [tksd_pkg::REM_W-1:0] lead_rem;
  logic                       lead_long;
  logic [tksd_pkg::REM_W-1:0] rem_dec;

  assign shifted = {cur.acc[tksd_pkg::KEY_W-tksd_pkg::BYTE_W-1:0], in_byte};
  assign utf_acc = {{(tksd_pkg::KEY_W-tksd_pkg::UTF_KEEP-tksd_pkg::BYTE_W){1'b0}},
                    cur.acc[tksd_pkg::UTF_KEEP-1:0], in_byte};
  assign rem_dec = (cur.remaining != '0) ? cur.remaining - 1'b1 : cur.remaining;

  always_comb begin
    lead_long = 1'b0;
    unique casez (in_byte)
      8'b110?_????: lead_rem = 3'd1;
      8'b1110_????: lead_rem = 3'd2;
      8'b1111_0???: lead_rem = 3'd3;
      8'b1111_10??: lead_rem = 3'd4;
      8'b1111_110?: lead_rem = 3'd5;
      8'b1111_1110: lead_rem = 3'd6;
      8'b1111_1111: begin
        lead_rem  = 3'd7;
        lead_long = 1'b1;
      end
      default: lead_rem = '0;
    endcase
  end

  always_comb begin
    nxt          = cur;
    res.valid    = 1'b0;
    res.key_code = '0;
    res.status   = tksd_pkg::ST_KEY;
    if (end_of_input) begin
      nxt.mode      = tksd_pkg::MODE_IDLE;
      nxt.remaining = '0;
      nxt.too_long  = 1'b0;
      if (cur.mode != tksd_pkg::MODE_ESC && cur.mode != tksd_pkg::MODE_CSI &&
          cur.mode != tksd_pkg::MODE_SS && cur.mode != tksd_pkg::MODE_UTF8) begin
        res.valid  = 1'b1;
        res.status = tksd_pkg::ST_EOI;
      end
    end else begin
      unique case (cur.mode)
        tksd_pkg::MODE_ESC: begin
          nxt.mode = tksd_pkg::MODE_IDLE;
          if (in_byte == tksd_pkg::CHAR_CSI) begin
            nxt.acc  = {{(tksd_pkg::KEY_W-2*tksd_pkg::BYTE_W){1'b0}},
                        tksd_pkg::CHAR_ESC, tksd_pkg::CHAR_CSI};
            nxt.mode = tksd_pkg::MODE_CSI;
          end else if (in_byte == tksd_pkg::CHAR_SS_N || in_byte == tksd_pkg::CHAR_SS_O) begin
            nxt.acc  = {{(tksd_pkg::KEY_W-2*tksd_pkg::BYTE_W){1'b0}},
                        tksd_pkg::CHAR_ESC, in_byte};
            nxt.mode = tksd_pkg::MODE_SS;
          end else if (in_byte >= tksd_pkg::CHAR_ALT_LO && in_byte <= tksd_pkg::CHAR_ALT_HI) begin
            res.valid    = 1'b1;
            res.key_code = {{(tksd_pkg::KEY_W-2*tksd_pkg::BYTE_W){1'b0}},
                            tksd_pkg::CHAR_ESC, in_byte};
          end else begin
            res.valid  = 1'b1;
            res.status = tksd_pkg::ST_UNKNOWN;
          end
        end
        tksd_pkg::MODE_CSI: begin
          nxt.acc = shifted;
          if (in_byte >= tksd_pkg::CSI_FINAL_LO && in_byte <= tksd_pkg::CSI_FINAL_HI) begin
            nxt.mode     = tksd_pkg::MODE_IDLE;
            res.valid    = 1'b1;
            res.key_code = shifted;
          end else if (cur.acc[55:48] != '0) begin
            nxt.mode   = tksd_pkg::MODE_IDLE;
            res.valid  = 1'b1;
            res.status = tksd_pkg::ST_CSI_LONG;
          end
        end
        tksd_pkg::MODE_SS: begin
          nxt.mode     = tksd_pkg::MODE_IDLE;
          nxt.acc      = shifted;
          res.valid    = 1'b1;
          res.key_code = shifted;
        end
        tksd_pkg::MODE_UTF8: begin
          nxt.acc       = utf_acc;
          nxt.remaining = rem_dec;
          if (rem_dec == '0) begin
            nxt.mode  = tksd_pkg::MODE_IDLE;
            res.valid = 1'b1;
            if (cur.too_long) begin
              nxt.too_long = 1'b0;
              res.status   = tksd_pkg::ST_UTF_LONG;
            end else begin
              res.key_code = utf_acc;
            end
          end
        end
        default: begin
          nxt.mode = tksd_pkg::MODE_IDLE;
          if (in_byte == tksd_pkg::CHAR_ESC) begin
            nxt.mode = tksd_pkg::MODE_ESC;
          end else if (in_byte <= tksd_pkg::PLAIN_MAX) begin
            res.valid    = 1'b1;
            res.key_code = {{(tksd_pkg::KEY_W-tksd_pkg::BYTE_W){1'b0}}, in_byte};
          end else if (in_byte < tksd_pkg::UTF_LEAD_MIN) begin
            res.valid  = 1'b1;
            res.status = tksd_pkg::ST_BAD_LEAD;
          end else begin
            nxt.acc       = {{(tksd_pkg::KEY_W-tksd_pkg::BYTE_W){1'b0}}, in_byte};
            nxt.remaining = lead_rem;
            nxt.too_long  = lead_long;
            nxt.mode      = tksd_pkg::MODE_UTF8;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/terminal_key_sequence_decoder_top.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_top
// Assembles terminal bytes into key codes and error status requests.
// ----------------------------------------------------------------------------
// A completing byte is held in the input register, and its result then in the
// output register; the byte waits while a held request is not yet accepted.
// Throughput: one byte per cycle while the output register is free or taken.
// A byte that completes no key produces no output request.
// Reset (rst, synchronous, active high) empties both stages and returns the
// parser to idle with a zero accumulator.
module terminal_key_sequence_decoder_top (
  input  logic         clk,
  input  logic         rst,
  tksd_byte_if.sink    byte_stream,
  tksd_key_if.source   key_stream
);

  logic                         in_vld;
  logic [tksd_pkg::BYTE_W-1:0]  in_byte_q;
  logic                         eoi_q;
  tksd_pkg::parse_state_t       state;
  tksd_pkg::parse_state_t       state_next;
  tksd_pkg::result_t            res;
  logic                         out_vld;
  logic [tksd_pkg::KEY_W-1:0]   key_code_q;
  tksd_pkg::status_t            status_q;
  logic                         advance;

  assign advance           = in_vld && (!out_vld || key_stream.ready);
  assign byte_stream.ready = !in_vld || advance;

  tksd_step u_step (
    .cur          (state),
    .in_byte      (in_byte_q),
    .end_of_input (eoi_q),
    .nxt          (state_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld          <= 1'b0;
      out_vld         <= 1'b0;
      state.mode      <= tksd_pkg::MODE_IDLE;
      state.acc       <= '0;
      state.remaining <= '0;
      state.too_long  <= 1'b0;
    end else begin
      if (byte_stream.valid && byte_stream.ready) begin
        in_vld    <= 1'b1;
        in_byte_q <= byte_stream.in_byte;
        eoi_q     <= byte_stream.end_of_input;
      end else if (advance) begin
        in_vld <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && res.valid) begin
        out_vld    <= 1'b1;
        key_code_q <= res.key_code;
        status_q   <= res.status;
      end else if (key_stream.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign key_stream.valid    = out_vld;
  assign key_stream.key_code = key_code_q;
  assign key_stream.status   = status_q;

endmodule

// File: tb/sv/terminal_key_sequence_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_top_tb
// Feeds terminal byte streams into the decoder and checks every key request.
// A short table of hand-picked bytes comes first. Random escape, CSI,
// single-shift, UTF-8, error and end-of-input sequences follow. A local
// decoder model predicts each request unless a table row gives its own.
// Sender and receiver stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder_top_tb;
  import tksd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_BYTES  = 300;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    status_t          status;
  } key_request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_val;
    logic              eoi;
    logic              typed;
    status_t           status;
    logic [KEY_W-1:0]  key;
  } stimulus_row_t;

  logic clk;
  logic rst;

  tksd_byte_if byte_if ();
  tksd_key_if  key_if ();

  terminal_key_sequence_decoder_top DUT (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .key_stream  (key_if)
  );

  key_request_t  pending_keys[$];
  stimulus_row_t directed_rows[$];

  mode_t             dec_mode;
  logic [63:0]       dec_acc;
  logic [REM_W-1:0]  dec_left;
  logic              dec_overlong;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned bytes_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  logic        hold_armed;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Decoder model: advances the parse state by one byte and reports the
  // key request that the byte completes, if any.
  task automatic predict_key(input logic [BYTE_W-1:0] b, input logic eoi,
                             output logic got, output key_request_t req);
    mode_t was;
    int    ones;
    got = 1'b0;
    req.key = '0;
    req.status = ST_KEY;
    if (eoi) begin
      was = dec_mode;
      dec_mode = MODE_IDLE;
      dec_left = '0;
      dec_overlong = 1'b0;
      if (was == MODE_IDLE) begin
        got = 1'b1;
        req.status = ST_EOI;
      end
      return;
    end
    case (dec_mode)
      MODE_ESC: begin
        if (b == CHAR_CSI) begin
          dec_acc = {48'h0, CHAR_ESC, CHAR_CSI};
          dec_mode = MODE_CSI;
        end else if (b == CHAR_SS_N || b == CHAR_SS_O) begin
          dec_acc = {48'h0, CHAR_ESC, b};
          dec_mode = MODE_SS;
        end else begin
          dec_mode = MODE_IDLE;
          got = 1'b1;
          if (b >= CHAR_ALT_LO && b <= CHAR_ALT_HI) begin
            req.key = {47'h0, CHAR_ESC, b};
          end else begin
            req.status = ST_UNKNOWN;
          end
        end
      end
      MODE_CSI: begin
        dec_acc = {dec_acc[55:0], b};
        if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) begin
          dec_mode = MODE_IDLE;
          got = 1'b1;
          req.key = dec_acc[KEY_W-1:0];
        end else if (dec_acc[63:56] != 8'h00) begin
          dec_mode = MODE_IDLE;
          got = 1'b1;
          req.status = ST_CSI_LONG;
        end
      end
      MODE_SS: begin
        dec_mode = MODE_IDLE;
        dec_acc = {dec_acc[55:0], b};
        got = 1'b1;
        req.key = dec_acc[KEY_W-1:0];
      end
      MODE_UTF8: begin
        dec_acc = {33'h0, dec_acc[UTF_KEEP-1:0], b};
        if (dec_left != 0) dec_left--;
        if (dec_left == 0) begin
          dec_mode = MODE_IDLE;
          got = 1'b1;
          if (dec_overlong) begin
            dec_overlong = 1'b0;
            req.status = ST_UTF_LONG;
          end else begin
            req.key = dec_acc[KEY_W-1:0];
          end
        end
      end
      default: begin
        dec_mode = MODE_IDLE;
        if (b == CHAR_ESC) begin
          dec_mode = MODE_ESC;
        end else if (b <= PLAIN_MAX) begin
          got = 1'b1;
          req.key = {55'h0, b};
        end else if (b < UTF_LEAD_MIN) begin
          got = 1'b1;
          req.status = ST_BAD_LEAD;
        end else begin
          ones = 0;
          for (int i = 7; i >= 0; i--) begin
            if (b[i] && ones == 7 - i) ones++;
          end
          dec_acc = {56'h0, b};
          dec_left = REM_W'(ones - 1);
          dec_overlong = (ones > 7);
          dec_mode = MODE_UTF8;
        end
      end
    endcase
  endtask

  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic eoi,
                            input logic typed = 1'b0,
                            input status_t typed_status = ST_KEY,
                            input logic [KEY_W-1:0] typed_key = '0);
    logic         got;
    key_request_t req;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid        <= 1'b1;
    byte_if.in_byte      <= b;
    byte_if.end_of_input <= eoi;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    bytes_taken++;
    predict_key(b, eoi, got, req);
    if (typed) begin
      req.key = typed_key;
      req.status = typed_status;
      got = 1'b1;
    end
    if (got) pending_keys.push_back(req);
  endtask

  task automatic wait_for_keys();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (pending_keys.size() != 0);
  endtask

  function automatic logic [BYTE_W-1:0] csi_param_byte();
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom_range(8'hEF, 8'hFF));
    return BYTE_W'($urandom_range(8'h00, 8'h3F));
  endfunction

  function automatic logic [BYTE_W-1:0] utf_lead_byte(input int ones);
    int top;
    int low;
    top = (255 << (8 - ones)) & 255;
    low = $urandom & (255 >> (ones + 1));
    return BYTE_W'(top | low);
  endfunction

  task automatic send_random_sequence();
    int                kind;
    int                n;
    int                k;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      b = BYTE_W'($urandom_range(8'h00, PLAIN_MAX));
      if (b == CHAR_ESC) b = 8'h40;
      offer_byte(b, 1'b0);
    end else if (kind < 30) begin
      offer_byte(CHAR_ESC, 1'b0);
      offer_byte(BYTE_W'($urandom_range(CHAR_ALT_LO, CHAR_ALT_HI)), 1'b0);
    end else if (kind < 38) begin
      offer_byte(CHAR_ESC, 1'b0);
      offer_byte($urandom_range(0, 1) ? CHAR_SS_N : CHAR_SS_O, 1'b0);
      offer_byte(BYTE_W'($urandom), 1'b0);
    end else if (kind < 56) begin
      offer_byte(CHAR_ESC, 1'b0);
      offer_byte(CHAR_CSI, 1'b0);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) offer_byte(csi_param_byte(), 1'b0);
      if (n < 6) offer_byte(BYTE_W'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)), 1'b0);
    end else if (kind < 74) begin
      n = $urandom_range(2, 8);
      offer_byte(utf_lead_byte(n), 1'b0);
      for (int i = 1; i < n; i++) begin
        if ($urandom_range(0, 4) != 0) offer_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)), 1'b0);
        else offer_byte(BYTE_W'($urandom), 1'b0);
      end
    end else if (kind < 80) begin
      do begin
        b = BYTE_W'($urandom);
      end while ((b >= CHAR_ALT_LO && b <= CHAR_ALT_HI) || b == CHAR_CSI ||
                 b == CHAR_SS_N || b == CHAR_SS_O);
      offer_byte(CHAR_ESC, 1'b0);
      offer_byte(b, 1'b0);
    end else if (kind < 85) begin
      offer_byte(BYTE_W'($urandom_range(PLAIN_MAX + 1, UTF_LEAD_MIN - 1)), 1'b0);
    end else if (kind < 90) begin
      offer_byte(BYTE_W'($urandom), 1'b1);
    end else if (kind < 95) begin
      case ($urandom_range(0, 3))
        0: offer_byte(CHAR_ESC, 1'b0);
        1: begin
          offer_byte(CHAR_ESC, 1'b0);
          offer_byte(CHAR_CSI, 1'b0);
          k = $urandom_range(0, 5);
          for (int i = 0; i < k; i++) offer_byte(csi_param_byte(), 1'b0);
        end
        2: begin
          offer_byte(CHAR_ESC, 1'b0);
          offer_byte($urandom_range(0, 1) ? CHAR_SS_N : CHAR_SS_O, 1'b0);
        end
        default: begin
          n = $urandom_range(2, 8);
          offer_byte(utf_lead_byte(n), 1'b0);
          k = $urandom_range(0, n - 2);
          for (int i = 0; i < k; i++) offer_byte(BYTE_W'($urandom), 1'b0);
        end
      endcase
      offer_byte(BYTE_W'($urandom), 1'b1);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) offer_byte(BYTE_W'($urandom), $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic add_row(input logic [BYTE_W-1:0] b, input logic eoi,
                         input logic typed = 1'b0, input status_t status = ST_KEY,
                         input logic [KEY_W-1:0] key = '0);
    stimulus_row_t row;
    row.in_val = b;
    row.eoi = eoi;
    row.typed = typed;
    row.status = status;
    row.key = key;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      key_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_armed) begin
      key_if.ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_armed = 1'b0;
    end else begin
      key_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    key_request_t exp_req;
    if (!rst && key_if.valid && key_if.ready) begin
      if (pending_keys.size() == 0) begin
        $error("unexpected key request: key_code %h, status %0d",
               key_if.key_code, key_if.status);
        mismatch_count++;
      end else begin
        exp_req = pending_keys.pop_front();
        if (key_if.key_code !== exp_req.key) begin
          $error("key_code mismatch: expected %h, actual %h", exp_req.key, key_if.key_code);
          mismatch_count++;
        end
        if (key_if.status !== exp_req.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_req.status, key_if.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned phase_start;
    logic        hold_done;
    clk = 1'b0;
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.in_byte = '0;
    byte_if.end_of_input = 1'b0;
    key_if.ready = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    bytes_taken = 0;
    hold_left = 0;
    hold_armed = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 58;
    dec_mode = MODE_IDLE;
    dec_acc = '0;
    dec_left = '0;
    dec_overlong = 1'b0;

    add_row(8'h00, 1'b1, 1'b1, ST_EOI);
    add_row(PLAIN_MAX, 1'b0, 1'b1, ST_KEY, 63'h80);
    add_row(BYTE_W'(PLAIN_MAX + 1), 1'b0, 1'b1, ST_BAD_LEAD);
    add_row(CHAR_ESC, 1'b0);
    add_row(CHAR_ALT_LO, 1'b0, 1'b1, ST_KEY, 63'h1B61);
    add_row(CHAR_ESC, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, ST_UNKNOWN);
    add_row(CHAR_ESC, 1'b0);
    add_row(CHAR_SS_N, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(CHAR_ESC, 1'b0);
    add_row(CHAR_CSI, 1'b0);
    add_row(CSI_FINAL_HI, 1'b0);
    add_row(CHAR_ESC, 1'b0);
    add_row(CHAR_CSI, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h3F, 1'b0);
    add_row(8'hEF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h30, 1'b0);
    add_row(8'h3B, 1'b0, 1'b1, ST_CSI_LONG);
    add_row(8'hC3, 1'b0);
    add_row(8'hFF, 1'b1);
    add_row(8'hFF, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'hBF, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h55, 1'b0);
    add_row(8'hAA, 1'b0);
    add_row(8'h80, 1'b0, 1'b1, ST_UTF_LONG);
    add_row(8'hDF, 1'b0);
    add_row(8'hBF, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, ST_KEY, 63'h0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].in_val, directed_rows[i].eoi, directed_rows[i].typed,
                 directed_rows[i].status, directed_rows[i].key);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 15 : 0;
      phase_start = bytes_taken;
      hold_done = (phase == 1);
      while (bytes_taken - phase_start < PHASE_BYTES) begin
        if (!hold_done && bytes_taken - phase_start >= 50) begin
          hold_armed = 1'b1;
          hold_done = 1'b1;
        end
        send_random_sequence();
      end
      // The sender stays quiet until every outstanding request is back.
      wait_for_keys();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
